// ===== design/ifmt_pkg.sv =====
package ifmt_pkg;

  // field limits
  localparam int MAX_WIDTH  = 64;
  localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
  localparam int FW_W       = 7;
  localparam int VAL_W      = 32;
  localparam int NDIG       = 11;
  localparam int DIG_IDX_W  = $clog2(NDIG);
  localparam int DEC_STEPS  = VAL_W;
  localparam int STEP_W     = $clog2(DEC_STEPS);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // ascii codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_O_LO  = 8'h6F;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_A_UP  = 8'h41;

  typedef enum logic [2:0] {
    K_SDEC = 3'd0,
    K_UDEC = 3'd1,
    K_OCT  = 3'd2,
    K_HEXL = 3'd3,
    K_HEXU = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_CONV = 2'd1,
    F_PUSH = 2'd2
  } front_state_e;

  typedef enum logic [2:0] {
    P_LEAD  = 3'd0,
    P_SIGN  = 3'd1,
    P_PFX0  = 3'd2,
    P_PFX1  = 3'd3,
    P_ZERO  = 3'd4,
    P_DIGIT = 3'd5,
    P_TRAIL = 3'd6,
    P_IDLE  = 3'd7
  } phase_e;

  typedef logic [NDIG-1:0][3:0] digits_t;

  // one classified item, ready for emission
  typedef struct packed {
    digits_t          digs;
    logic [3:0]       nd;
    logic             has_sign;
    logic [7:0]       sign_ch;
    logic             has_pfx;
    logic [7:0]       pfx_ch;
    logic             upper;
    logic             lj;
    logic             zp;
    logic [CNT_W-1:0] pad;
    logic [CNT_W-1:0] total;
  } entry_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = (upper ? CH_A_UP : CH_A_LO) + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== design/ifmt_front.sv =====
module ifmt_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               kind_i,
  input  logic [ifmt_pkg::VAL_W-1:0] value_i,
  input  logic [ifmt_pkg::FW_W-1:0]  field_width_i,
  input  logic                     left_justify_i,
  input  logic                     zero_pad_i,
  input  logic                     force_plus_i,
  input  logic                     space_sign_i,
  input  logic                     show_prefix_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output ifmt_pkg::entry_t         q_entry_o
);
  import ifmt_pkg::*;

  front_state_e       state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [VAL_W-1:0]   sh_q, sh_d;
  digits_t            digs_q, digs_d;
  logic               has_sign_q, has_sign_d;
  logic [7:0]         sign_ch_q, sign_ch_d;
  logic               has_pfx_q, has_pfx_d;
  logic [7:0]         pfx_ch_q, pfx_ch_d;
  logic               upper_q, upper_d;
  logic               lj_q, lj_d;
  logic               zp_q, zp_d;
  logic [FW_W-1:0]    fw_q, fw_d;

  logic               accept, bad, neg;
  logic [VAL_W-1:0]   mag;
  logic [VAL_W:0]     mag_ext;
  digits_t            oct_digs;
  logic [4*NDIG-1:0]  adj;
  logic [3:0]         nd;
  logic [3:0]         w;
  logic [CNT_W-1:0]   fwc;
  logic [CNT_W-1:0]   pad;

  assign busy   = (state_q != F_IDLE);
  assign accept = start && !busy;
  assign bad    = !(kind_i inside {[K_SDEC:K_HEXU]}) ||
                  (left_justify_i && zero_pad_i) || (force_plus_i && space_sign_i);
  assign neg    = (kind_i == K_SDEC) && value_i[VAL_W-1];
  assign mag    = neg ? (~value_i + 1'b1) : value_i;
  assign mag_ext = {1'b0, mag};

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      oct_digs[i] = {1'b0, mag_ext[3*i +: 3]};
    end
  end

  // add-3 correction of the bcd digits
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = (digs_q[i] >= 4'd5) ? digs_q[i] + 4'd3 : digs_q[i];
    end
  end

  // digit count, width and padding of the finished field
  always_comb begin
    nd = 4'd1;
    for (int i = 0; i < NDIG; i++) begin
      if (digs_q[i] != 4'd0) begin
        nd = 4'(i + 1);
      end
    end
    w   = {3'b0, has_sign_q} + (has_pfx_q ? 4'd2 : 4'd0) + nd;
    fwc = (fw_q > FW_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : CNT_W'(fw_q);
    pad = (fwc > CNT_W'(w)) ? fwc - CNT_W'(w) : '0;
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    sh_d       = sh_q;
    digs_d     = digs_q;
    has_sign_d = has_sign_q;
    sign_ch_d  = sign_ch_q;
    has_pfx_d  = has_pfx_q;
    pfx_ch_d   = pfx_ch_q;
    upper_d    = upper_q;
    lj_d       = lj_q;
    zp_d       = zp_q;
    fw_d       = fw_q;
    q_push_o   = 1'b0;

    case (state_q)
      F_IDLE: begin
        if (accept && !bad) begin
          has_sign_d = neg || force_plus_i || space_sign_i;
          sign_ch_d  = neg ? CH_MINUS : (force_plus_i ? CH_PLUS : CH_SPACE);
          has_pfx_d  = show_prefix_i && (kind_i inside {[K_OCT:K_HEXU]});
          pfx_ch_d   = (kind_i == K_OCT) ? CH_O_LO : ((kind_i == K_HEXL) ? CH_X_LO : CH_X_UP);
          upper_d    = (kind_i == K_HEXU);
          lj_d       = left_justify_i;
          zp_d       = zero_pad_i;
          fw_d       = field_width_i;
          sh_d       = mag;
          step_d     = '0;
          case (kind_i)
            K_SDEC, K_UDEC: begin
              digs_d  = '0;
              state_d = F_CONV;
            end
            K_OCT: begin
              digs_d  = oct_digs;
              state_d = F_PUSH;
            end
            default: begin
              digs_d  = digits_t'({{(4*NDIG-VAL_W){1'b0}}, mag});
              state_d = F_PUSH;
            end
          endcase
        end
      end
      F_CONV: begin
        digs_d = {adj[4*NDIG-2:0], sh_q[VAL_W-1]};
        sh_d   = {sh_q[VAL_W-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DEC_STEPS - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_comb begin
    q_entry_o.digs     = digs_q;
    q_entry_o.nd       = nd;
    q_entry_o.has_sign = has_sign_q;
    q_entry_o.sign_ch  = sign_ch_q;
    q_entry_o.has_pfx  = has_pfx_q;
    q_entry_o.pfx_ch   = pfx_ch_q;
    q_entry_o.upper    = upper_q;
    q_entry_o.lj       = lj_q;
    q_entry_o.zp       = zp_q;
    q_entry_o.pad      = pad;
    q_entry_o.total    = pad + CNT_W'(w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q       <= sh_d;
    digs_q     <= digs_d;
    has_sign_q <= has_sign_d;
    sign_ch_q  <= sign_ch_d;
    has_pfx_q  <= has_pfx_d;
    pfx_ch_q   <= pfx_ch_d;
    upper_q    <= upper_d;
    lj_q       <= lj_d;
    zp_q       <= zp_d;
    fw_q       <= fw_d;
  end

  a_conv_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_CONV && step_q == STEP_W'(DEC_STEPS - 1)) |=> (state_q == F_PUSH))
    else $error("conversion did not end after its last step");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !bad) |=> busy)
    else $error("valid item taken without going busy");

endmodule

// ===== design/ifmt_fifo.sv =====
module ifmt_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ifmt_pkg::entry_t  wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output ifmt_pkg::entry_t  rdata_o
);
  import ifmt_pkg::*;

  entry_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_PTR_W:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (push_i ? 1'b1 : 1'b0) - (pop_i ? 1'b1 : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule

// ===== design/ifmt_back.sv =====
module ifmt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  ifmt_pkg::entry_t q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  output logic [7:0]       out_char_o,
  output logic             last_char_o
);
  import ifmt_pkg::*;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  entry_t           ent_q, ent_d;
  logic             valid_q;
  logic [7:0]       char_q, char_d;
  logic             last_q;

  logic             emit, finish, load, phase_done;
  logic [CNT_W-1:0] len;
  logic [DIG_IDX_W-1:0] di;

  // phases that hold at least one character
  function automatic logic [6:0] phase_mask(input entry_t e);
    logic [6:0] m;
    m[0] = !e.zp && !e.lj && (e.pad != '0);
    m[1] = e.has_sign;
    m[2] = e.has_pfx;
    m[3] = e.has_pfx;
    m[4] = e.zp && (e.pad != '0);
    m[5] = 1'b1;
    m[6] = e.lj && (e.pad != '0);
    return m;
  endfunction

  function automatic phase_e first_phase(input logic [6:0] m, input logic [2:0] from);
    phase_e p;
    p = P_IDLE;
    for (int k = 6; k >= 0; k--) begin
      if (m[k] && (3'(k) >= from)) begin
        p = phase_e'(3'(k));
      end
    end
    return p;
  endfunction

  function automatic logic [CNT_W-1:0] phase_len(input phase_e p, input entry_t e);
    logic [CNT_W-1:0] l;
    case (p)
      P_LEAD, P_ZERO, P_TRAIL: l = e.pad;
      P_SIGN, P_PFX0, P_PFX1:  l = CNT_W'(1);
      P_DIGIT:                 l = CNT_W'(e.nd);
      default:                 l = '0;
    endcase
    return l;
  endfunction

  assign emit       = (phase_q != P_IDLE);
  assign finish     = emit && (rem_q == CNT_W'(1));
  assign load       = (!emit || finish) && !q_empty_i;
  assign q_pop_o    = load;
  assign len        = phase_len(phase_q, ent_q);
  assign phase_done = (CNT_W'(cnt_q + 1'b1) == len);
  assign di         = DIG_IDX_W'(ent_q.nd - 4'd1 - cnt_q[3:0]);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    ent_d   = ent_q;
    if (load) begin
      ent_d   = q_entry_i;
      phase_d = first_phase(phase_mask(q_entry_i), 3'd0);
      cnt_d   = '0;
      rem_d   = q_entry_i.total;
    end else if (finish) begin
      phase_d = P_IDLE;
    end else if (emit) begin
      rem_d = rem_q - 1'b1;
      if (phase_done) begin
        phase_d = first_phase(phase_mask(ent_q), phase_q + 3'd1);
        cnt_d   = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    case (phase_q)
      P_SIGN:  char_d = ent_q.sign_ch;
      P_PFX0:  char_d = CH_ZERO;
      P_PFX1:  char_d = ent_q.pfx_ch;
      P_ZERO:  char_d = CH_ZERO;
      P_DIGIT: char_d = digit_char(ent_q.digs[di], ent_q.upper);
      default: char_d = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      valid_q <= emit;
      last_q  <= finish;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    char_q <= char_d;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (rem_q != '0))
    else $error("emitting with no characters left");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && q_empty_i) |=> (phase_q == P_IDLE))
    else $error("emission went on past the last character");

endmodule

// ===== design/integer_field_formatter_core.sv =====
// printf-style integer field formatter
// an item is taken on a rising edge with start high and busy low: kind_i,
// value_i, field_width_i and the five flag inputs. the item's characters
// leave one per cycle on out_char_o while out_valid_o is high; last_char_o
// marks the final character of each field. items with an unknown kind or
// with conflicting flags (left justify with zero pad, plus with space) are
// taken and give no characters.
// the front converts: hex and octal are split into digits at accept,
// decimal goes through a 32-step shift-add-3 loop, one bit per cycle. the
// front then pushes a field descriptor into a two-entry queue and is free
// again. busy is high after accept through the push cycle, and longer only
// while the queue is full, so no item is taken before the last is pushed.
// the back pops descriptors and emits one character per cycle through an
// output register, back to back across fields when the queue is not empty.
// with the back idle, a pushed descriptor passes the queue register, the
// back's phase register and the output register before its first
// character is on the ports. the front can convert the next item while
// the back is still emitting a field.
// reset clears the queue and both state machines; the receiver cannot
// stall, so every strobe is a delivered character.
module integer_field_formatter_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                kind_i,
  input  logic [ifmt_pkg::VAL_W-1:0] value_i,
  input  logic [ifmt_pkg::FW_W-1:0]  field_width_i,
  input  logic                      left_justify_i,
  input  logic                      zero_pad_i,
  input  logic                      force_plus_i,
  input  logic                      space_sign_i,
  input  logic                      show_prefix_i,
  output logic                      out_valid_o,
  output logic [7:0]                out_char_o,
  output logic                      last_char_o
);
  import ifmt_pkg::*;

  // front to queue
  logic    q_push;
  entry_t  push_entry;
  logic    q_full;

  // queue to back
  entry_t  head_entry;
  logic    q_empty;
  logic    q_pop;

  ifmt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .field_width_i  (field_width_i),
    .left_justify_i (left_justify_i),
    .zero_pad_i     (zero_pad_i),
    .force_plus_i   (force_plus_i),
    .space_sign_i   (space_sign_i),
    .show_prefix_i  (show_prefix_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (push_entry)
  );

  // descriptor queue decouples conversion from emission
  ifmt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (head_entry)
  );

  ifmt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_entry_i   (head_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule
